// ===== rtl/dbsg_pkg.sv =====
// Shared types, band codes and decimal digit helpers for the speed governor.
package dbsg_pkg;

    localparam int DistW   = 16;
    localparam int LevelW  = 7;
    localparam int PwmW    = 14;
    localparam int CharW   = 6;
    localparam int DigitW  = 4;
    localparam int DModW   = 10;
    localparam int BandW   = 3;

    // distance bands, decided once at the input register
    localparam logic [BandW-1:0] BAND_FAR   = 3'd0;
    localparam logic [BandW-1:0] BAND_WARN  = 3'd1;
    localparam logic [BandW-1:0] BAND_MID   = 3'd2;
    localparam logic [BandW-1:0] BAND_NEAR  = 3'd3;
    localparam logic [BandW-1:0] BAND_STOP  = 3'd4;
    localparam logic [BandW-1:0] BAND_FIFTY = 3'd5;

    localparam logic [CharW-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [BandW-1:0] band;
        logic [DModW-1:0] dist_mod;
    } t_in_item;

    typedef struct packed {
        logic [DigitW-1:0] hundreds;
        logic [DigitW-1:0] tens;
        logic [DigitW-1:0] ones;
    } t_digits;

    // Split 0..999 into decimal digits with reciprocal multiplies (x41>>12, x205>>11).
    function automatic t_digits f_split3(input logic [DModW-1:0] n);
        logic [15:0]       p_h;
        logic [DigitW-1:0] h;
        logic [6:0]        rem;
        logic [14:0]       p_t;
        logic [DigitW-1:0] t;
        t_digits           d;
        p_h = 16'(n) * 16'd41;
        h   = p_h[15:12];
        rem = 7'(n - 10'(h) * 10'd100);
        p_t = 15'(rem) * 15'd205;
        t   = p_t[14:11];
        d.hundreds = h;
        d.tens     = t;
        d.ones     = 4'(rem - 7'(t) * 7'd10);
        return d;
    endfunction

endpackage

// ===== rtl/dbsg_in_stage.sv =====
// Input register: classify the distance into a band and reduce it mod 1000.
module dbsg_in_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [15:0]             i_s_tdata,   // [15:0] distance
    input  logic                    i_adv,
    output logic                    o_item_valid,
    output dbsg_pkg::t_in_item      o_item
);
    import dbsg_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    t_in_item n_item;

    // quotient estimate never exceeds the true one and is short by at most one
    function automatic logic [DModW-1:0] f_mod1000(input logic [DistW-1:0] d);
        logic [26:0] p;
        logic [6:0]  q;
        logic [16:0] r;
        p = 27'(d) * 27'd1048;
        q = p[26:20];
        r = 17'(d) - 17'(q) * 17'd1000;
        if (r >= 17'd1000) begin
            r = r - 17'd1000;
        end
        return r[DModW-1:0];
    endfunction

    always_comb begin
        priority if (i_s_tdata >= 16'd100) begin
            n_item.band = BAND_FAR;
        end else if (i_s_tdata >= 16'd75) begin
            n_item.band = BAND_WARN;
        end else if (i_s_tdata > 16'd50) begin
            n_item.band = BAND_MID;
        end else if (i_s_tdata == 16'd50) begin
            n_item.band = BAND_FIFTY;
        end else if (i_s_tdata > 16'd25) begin
            n_item.band = BAND_NEAR;
        end else begin
            n_item.band = BAND_STOP;
        end
        n_item.dist_mod = f_mod1000(i_s_tdata);
    end

    assign o_s_tready   = !r_valid || i_adv;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/dbsg_level.sv =====
// Speed level and buzzer state with the per-band update rules.
module dbsg_level (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [dbsg_pkg::BandW-1:0]      i_band,
    output logic [dbsg_pkg::LevelW-1:0]     o_level,
    output logic                            o_buzzer
);
    import dbsg_pkg::*;

    logic [LevelW-1:0] r_level;
    logic              r_buzzer;
    logic [LevelW-1:0] n_level;
    logic              n_buzzer;
    logic [LevelW-1:0] w_inc;
    logic [LevelW-1:0] w_dec;
    logic [LevelW-1:0] w_rise;

    assign w_inc  = r_level + 7'd1;
    assign w_dec  = r_level - 7'd2;
    // clamp only the band just above the ceiling; a wrapped level passes
    assign w_rise = (w_inc >= 7'd120 && w_inc <= 7'd125) ? 7'd120 : w_inc;

    always_comb begin
        n_level  = r_level;
        n_buzzer = r_buzzer;
        unique case (i_band)
            BAND_FAR: begin
                n_level  = w_rise;
                n_buzzer = 1'b0;
            end
            BAND_WARN: begin
                n_level  = w_rise;
                n_buzzer = 1'b1;
            end
            BAND_MID: begin
                priority if (r_level > 7'd45) begin
                    n_level  = w_dec;
                    n_buzzer = 1'b1;
                end else if (r_level < 7'd40) begin
                    n_level  = w_inc;
                    n_buzzer = 1'b1;
                end else begin
                    n_level  = 7'd45;
                end
            end
            BAND_NEAR: begin
                priority if (r_level > 7'd30) begin
                    n_level  = w_dec;
                    n_buzzer = 1'b1;
                end else if (r_level < 7'd28) begin
                    n_level  = w_inc;
                    n_buzzer = 1'b1;
                end else begin
                    n_level  = 7'd30;
                end
            end
            BAND_STOP: begin
                n_level  = 7'd0;
                n_buzzer = 1'b0;
            end
            default: begin
                // exactly fifty: hold both
                n_level  = r_level;
                n_buzzer = r_buzzer;
            end
        endcase
    end

    assign o_level  = n_level;
    assign o_buzzer = n_buzzer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 7'd0;
            r_buzzer <= 1'b0;
        end else if (i_adv) begin
            r_level  <= n_level;
            r_buzzer <= n_buzzer;
        end
    end

endmodule

// ===== rtl/distance_band_speed_governor_core.sv =====
// Top level of the distance band speed governor: stream ports and result register.
//
// Each request on the slave stream carries one obstacle distance. The block
// sorts it into a band (far, warning, middle, near, stop, or exactly fifty),
// updates its stored speed level and buzzer flag, and returns one result
// request with the new level, the PWM compare value (100 times the level),
// the buzzer drive, and ASCII digits of the level and of the distance mod
// 1000. A request passes through the input register and then the result
// register; a new request is taken every cycle, set by the single level update
// between those two registers, as long as the master side keeps taking results.
// Level and buzzer clear to zero on reset. Result tdata packing, lowest bit up:
// speed_level[6:0], pwm_compare[20:7], buzzer_on[21], speed_hundreds_char[27:22],
// speed_tens_char[33:28], speed_ones_char[39:34], dist_hundreds_char[45:40],
// dist_tens_char[51:46], dist_ones_char[57:52], zeros[63:58].
module distance_band_speed_governor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] distance
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // level, pwm, buzzer, 3 level chars, 3 distance chars
);
    import dbsg_pkg::*;

    logic              w_item_valid;
    t_in_item          w_item;
    logic              w_out_adv;
    logic              w_fire;
    logic [LevelW-1:0] w_level;
    logic              w_buzzer;

    logic              r_out_valid;
    logic [LevelW-1:0] r_level;
    logic [PwmW-1:0]   r_pwm;
    logic              r_buzzer;
    t_digits           r_sdig;
    t_digits           r_ddig;

    // the result register frees up when empty or when its request is taken
    assign w_out_adv = !r_out_valid || i_m_tready;
    assign w_fire    = w_item_valid && w_out_adv;

    dbsg_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_adv        (w_out_adv),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    // level state advances exactly when a staged request moves to the result
    dbsg_level u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_fire),
        .i_band   (w_item.band),
        .o_level  (w_level),
        .o_buzzer (w_buzzer)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_item_valid;
        end
    end

    // capture the payload of the advancing request
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_level  <= w_level;
            r_pwm    <= PwmW'(w_level) * 14'd100;
            r_buzzer <= w_buzzer;
            r_sdig   <= f_split3(DModW'(w_level));
            r_ddig   <= f_split3(w_item.dist_mod);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0,
                         ASCII_ZERO + CharW'(r_ddig.ones),
                         ASCII_ZERO + CharW'(r_ddig.tens),
                         ASCII_ZERO + CharW'(r_ddig.hundreds),
                         ASCII_ZERO + CharW'(r_sdig.ones),
                         ASCII_ZERO + CharW'(r_sdig.tens),
                         ASCII_ZERO + CharW'(r_sdig.hundreds),
                         r_buzzer,
                         r_pwm,
                         r_level};

`ifndef SYNTHESIS
    // level stays under the ceiling once out of reset
    a_level_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_level <= 7'd120))
        else $error("speed level above ceiling");

    a_pwm_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_pwm == PwmW'(r_level) * 14'd100))
        else $error("pwm compare out of step with level");

    a_level_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (10'(r_sdig.hundreds) * 10'd100 + 10'(r_sdig.tens) * 10'd10
                         + 10'(r_sdig.ones) == 10'(r_level)))
        else $error("level digits do not rebuild the level");
`endif

endmodule
